// File: rtl/pfb_pkg.sv
// shared constants, codes and types of the page framebuffer block
package pfb_pkg;

	// frame geometry
	localparam int WIDTH       = 128;
	localparam int HEIGHT      = 64;
	localparam int PAGES       = (HEIGHT + 7) / 8;
	localparam int STORE_BYTES = WIDTH * PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	// command field widths
	localparam int XW = 7;
	localparam int YW = 6;
	localparam int PW = YW - 3;

	// byte constants
	localparam logic [7:0] PAT_ODD   = 8'hAA;
	localparam logic [7:0] PAT_EVEN  = 8'h55;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// command codes
	typedef enum logic [2:0] {
		OP_SET   = 3'd0,
		OP_CLEAR = 3'd1,
		OP_INV   = 3'd2,
		OP_SHADE = 3'd3,
		OP_FILL0 = 3'd4,
		OP_FILL1 = 3'd5,
		OP_READ  = 3'd6,
		OP_NOP   = 3'd7
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_MODIFY,
		ST_OUT
	} state_t;

endpackage

// File: rtl/pfb_if.sv
// command and response channels of the page framebuffer block

interface pfb_cmd_if;
	logic                   valid;
	logic                   ready;
	logic [2:0]             opcode;
	logic [pfb_pkg::XW-1:0] corner_x0;
	logic [pfb_pkg::YW-1:0] corner_y0;
	logic [pfb_pkg::XW-1:0] corner_x1;
	logic [pfb_pkg::YW-1:0] corner_y1;
	logic [9:0]             read_address;

	modport source (
		output valid, opcode, corner_x0, corner_y0, corner_x1, corner_y1, read_address,
		input  ready
	);
	modport sink (
		input  valid, opcode, corner_x0, corner_y0, corner_x1, corner_y1, read_address,
		output ready
	);
endinterface

interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/page_framebuffer_rect_ops.sv
// page-layout monochrome frame store with rectangle raster operations
// rectangle op: each covered byte is read, then written on the store port; read byte: the
//   store read is captured; fill 0x00/0xFF: one byte per cycle over STORE_BYTES (1024) bytes
// one command at a time; the next word can be taken in the cycle after the response word is taken
// reset: arst_n clears control at once, then a clearing pass writes zero over all 1024 bytes,
//   one per cycle, with cmd.ready low until the pass is done
module page_framebuffer_rect_ops (
	input  logic      clk,
	input  logic      arst_n,
	pfb_cmd_if.sink   cmd,
	pfb_rsp_if.source rsp
);

	localparam logic [pfb_pkg::ADDR_W-1:0] LAST_ADDR  = pfb_pkg::ADDR_W'(pfb_pkg::STORE_BYTES - 1);
	localparam logic [pfb_pkg::ADDR_W-1:0] ROW_STRIDE = pfb_pkg::ADDR_W'(pfb_pkg::WIDTH);
	localparam logic [pfb_pkg::XW-1:0]     X_MAX      = pfb_pkg::XW'(pfb_pkg::WIDTH - 1);
	localparam logic [pfb_pkg::YW-1:0]     Y_MAX      = pfb_pkg::YW'(pfb_pkg::HEIGHT - 1);

	// frame store
	logic [7:0] mem [pfb_pkg::STORE_BYTES];

	pfb_pkg::state_t state_q, state_d;
	pfb_pkg::op_t    op_q;
	logic [pfb_pkg::ADDR_W-1:0] sweep_q;
	logic [7:0]                 fill_q;

	logic [pfb_pkg::XW-1:0]     x_q, x0_q, x1_q;
	logic [pfb_pkg::PW-1:0]     page_q, p0_q, p1_q;
	logic [2:0]                 y0_lo_q, y1_lo_q;
	logic [pfb_pkg::ADDR_W-1:0] base_q;
	logic [7:0]                 rdata_q;
	logic [7:0]                 data_q;

	logic                       accept;
	logic                       mem_we;
	logic [pfb_pkg::ADDR_W-1:0] mem_addr;
	logic [pfb_pkg::ADDR_W-1:0] rect_addr;
	logic [7:0]                 mem_wdata;
	logic [7:0]                 mask;
	logic [7:0]                 pat;
	logic                       row_end;
	logic                       last_byte;

	// sorted and clipped corners of the incoming word
	logic [pfb_pkg::XW-1:0] in_xlo, in_xhi;
	logic [pfb_pkg::YW-1:0] in_ylo, in_yhi;
	pfb_pkg::op_t           in_op;
	logic                   in_addr_ok;

	always_comb begin
		in_op  = pfb_pkg::op_t'(cmd.opcode);
		in_xlo = (cmd.corner_x1 < cmd.corner_x0) ? cmd.corner_x1 : cmd.corner_x0;
		in_xhi = (cmd.corner_x1 < cmd.corner_x0) ? cmd.corner_x0 : cmd.corner_x1;
		in_ylo = (cmd.corner_y1 < cmd.corner_y0) ? cmd.corner_y1 : cmd.corner_y0;
		in_yhi = (cmd.corner_y1 < cmd.corner_y0) ? cmd.corner_y0 : cmd.corner_y1;
		if (int'(in_xlo) >= pfb_pkg::WIDTH) begin
			in_xlo = X_MAX;
		end
		if (int'(in_xhi) >= pfb_pkg::WIDTH) begin
			in_xhi = X_MAX;
		end
		if (int'(in_ylo) >= pfb_pkg::HEIGHT) begin
			in_ylo = Y_MAX;
		end
		if (int'(in_yhi) >= pfb_pkg::HEIGHT) begin
			in_yhi = Y_MAX;
		end
		in_addr_ok = int'(cmd.read_address) < pfb_pkg::STORE_BYTES;
	end

	assign accept = cmd.valid && cmd.ready;

	// per-byte mask, shade pattern, store address and walk end flags
	always_comb begin
		mask = pfb_pkg::BYTE_ONES;
		if (page_q == p0_q) begin
			mask = mask & (pfb_pkg::BYTE_ONES << y0_lo_q);
		end
		if (page_q == p1_q) begin
			mask = mask & (pfb_pkg::BYTE_ONES >> (3'd7 - y1_lo_q));
		end
		pat       = x_q[0] ? pfb_pkg::PAT_ODD : pfb_pkg::PAT_EVEN;
		rect_addr = base_q + pfb_pkg::ADDR_W'(x_q);
		row_end   = (x_q == x1_q);
		last_byte = row_end && (page_q == p1_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfb_pkg::ST_INIT: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			pfb_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_op) inside
						pfb_pkg::OP_SET, pfb_pkg::OP_CLEAR, pfb_pkg::OP_INV,
						pfb_pkg::OP_SHADE: state_d = pfb_pkg::ST_READ;
						pfb_pkg::OP_FILL0, pfb_pkg::OP_FILL1: state_d = pfb_pkg::ST_FILL;
						pfb_pkg::OP_READ: state_d = in_addr_ok ? pfb_pkg::ST_READ
						                                      : pfb_pkg::ST_OUT;
						default: state_d = pfb_pkg::ST_OUT;
					endcase
				end
			end
			pfb_pkg::ST_FILL: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = pfb_pkg::ST_OUT;
				end
			end
			pfb_pkg::ST_READ: state_d = pfb_pkg::ST_MODIFY;
			pfb_pkg::ST_MODIFY: begin
				if (op_q == pfb_pkg::OP_READ || last_byte) begin
					state_d = pfb_pkg::ST_OUT;
				end else begin
					state_d = pfb_pkg::ST_READ;
				end
			end
			pfb_pkg::ST_OUT: begin
				if (rsp.ready) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			default: state_d = pfb_pkg::ST_INIT;
		endcase
	end

	// outputs and store port control
	always_comb begin
		cmd.ready     = 1'b0;
		rsp.valid     = 1'b0;
		mem_we        = 1'b0;
		mem_addr      = rect_addr;
		mem_wdata     = rdata_q;
		rsp.read_data = data_q;
		case (state_q)
			pfb_pkg::ST_INIT, pfb_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_addr  = sweep_q;
				mem_wdata = fill_q;
			end
			pfb_pkg::ST_IDLE: cmd.ready = 1'b1;
			pfb_pkg::ST_MODIFY: begin
				mem_we = (op_q != pfb_pkg::OP_READ);
				case (op_q)
					pfb_pkg::OP_SET:   mem_wdata = rdata_q | mask;
					pfb_pkg::OP_CLEAR: mem_wdata = rdata_q & ~mask;
					pfb_pkg::OP_INV:   mem_wdata = rdata_q ^ mask;
					default:           mem_wdata = rdata_q | (mask & pat);
				endcase
			end
			pfb_pkg::ST_OUT: rsp.valid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfb_pkg::ST_INIT;
			sweep_q <= '0;
			fill_q  <= pfb_pkg::BYTE_ZERO;
			op_q    <= pfb_pkg::OP_NOP;
		end else begin
			state_q <= state_d;
			if (state_q == pfb_pkg::ST_INIT || state_q == pfb_pkg::ST_FILL) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (accept) begin
				op_q    <= in_op;
				sweep_q <= '0;
				fill_q  <= (in_op == pfb_pkg::OP_FILL1) ? pfb_pkg::BYTE_ONES
				                                         : pfb_pkg::BYTE_ZERO;
			end
		end
	end

	// rectangle walk and response data
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q    <= in_xlo;
			x1_q    <= in_xhi;
			y0_lo_q <= in_ylo[2:0];
			y1_lo_q <= in_yhi[2:0];
			p0_q    <= in_ylo[pfb_pkg::YW-1:3];
			p1_q    <= in_yhi[pfb_pkg::YW-1:3];
			page_q  <= in_ylo[pfb_pkg::YW-1:3];
			data_q  <= pfb_pkg::BYTE_ZERO;
			if (in_op == pfb_pkg::OP_READ) begin
				x_q    <= '0;
				base_q <= cmd.read_address;
			end else begin
				x_q    <= in_xlo;
				base_q <= pfb_pkg::ADDR_W'(int'(in_ylo[pfb_pkg::YW-1:3]) * pfb_pkg::WIDTH);
			end
		end else if (state_q == pfb_pkg::ST_MODIFY) begin
			if (op_q == pfb_pkg::OP_READ) begin
				data_q <= rdata_q;
			end else if (row_end) begin
				x_q    <= x0_q;
				page_q <= page_q + 1'b1;
				base_q <= base_q + ROW_STRIDE;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// store port: an optional write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	// only read commands return a nonzero byte
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && op_q != pfb_pkg::OP_READ) |-> rsp.read_data == pfb_pkg::BYTE_ZERO)
		else $error("nonzero response for a non-read command");

	// the store is written only by a sweep or a modify step
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == pfb_pkg::ST_INIT || state_q == pfb_pkg::ST_FILL ||
		            state_q == pfb_pkg::ST_MODIFY))
		else $error("store write outside a write phase");

	// the rectangle walk never passes the last page or column
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfb_pkg::ST_READ && op_q != pfb_pkg::OP_READ) |->
		(page_q <= p1_q && x_q <= x1_q && x_q >= x0_q))
		else $error("rectangle walk out of bounds");

	// a command is never taken while a response is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !cmd.ready)
		else $error("command accepted with response pending");

endmodule
